// ----- hw/rtl/gppe_pkg.sv -----
package gppe_pkg;

  localparam int IDX_W       = 8;
  localparam int OFF_W       = 11;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [BYTE_W:0] GF_POLY = 9'h11d;

  localparam logic [BYTE_W-1:0] EVAL_POINT_RST  = 8'd1;
  localparam logic [BYTE_W-1:0] NUM_SOURCES_RST = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EVAL_POINT  = 1'b0,
    REG_NUM_SOURCES = 1'b1
  } cfg_reg_t;

  // Shift-and-add multiply in GF(256), reducing by the field polynomial.
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] r;
    x = a;
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        r = r ^ x;
      end
      if (x[BYTE_W-1]) begin
        x = {x[BYTE_W-2:0], 1'b0} ^ GF_POLY[BYTE_W-1:0];
      end else begin
        x = {x[BYTE_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/gppe_col_ram.sv -----
module gppe_col_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [gppe_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [gppe_pkg::BYTE_W-1:0] rdata
);
  import gppe_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/gf256_packet_parity_encoder_unit.sv -----
// Builds one parity packet as the GF(256) polynomial (field 0x11d) whose
// coefficients are the source packets, evaluated per byte column at
// eval_point by Horner's rule. For each byte offset, feed the packets from
// index num_sources-1 down to 0; index 0 returns the parity byte of that
// column. Items with an index at or above num_sources, or an offset at or
// beyond PACKET_BYTES, are dropped without a result. One transaction is
// accepted every cycle while the input is not stalled; a parity byte passes
// through stage 1 to the output register. The column memory is read into the
// same register stage as the input. The input stalls only while a finished
// column waits behind a result that has not been taken. The column memory is
// not cleared: a column must start with its top index. The user must write
// configuration only while the block is idle; the block does not enforce it.
module gf256_packet_parity_encoder_unit #(
  parameter int PACKET_BYTES = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gppe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gppe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: packet_index[7:0], byte_offset[18:8], data_byte[26:19].
  input  logic [gppe_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: out_offset[10:0], parity_byte[18:11].
  output logic [gppe_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import gppe_pkg::*;

  localparam int AW    = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int EXT_W = AW + OFF_W;

  logic [BYTE_W-1:0] eval_point;
  logic [BYTE_W-1:0] num_sources;

  logic [IDX_W-1:0]  in_idx;
  logic [OFF_W-1:0]  in_off;
  logic [BYTE_W-1:0] in_data;
  logic [EXT_W-1:0]  in_off_ext;
  logic [AW-1:0]     in_addr;
  logic              in_keep;
  logic              s_fire;

  logic              s1_valid;
  logic              s1_top;
  logic              s1_emit;
  logic [AW-1:0]     s1_addr;
  logic [OFF_W-1:0]  s1_off;
  logic [BYTE_W-1:0] s1_data;
  logic              s1_fire;
  logic              byp_hit;
  logic [BYTE_W-1:0] byp_val;

  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] acc_old;
  logic [BYTE_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_point  <= EVAL_POINT_RST;
      num_sources <= NUM_SOURCES_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EVAL_POINT:  eval_point  <= cfg_data[BYTE_W-1:0];
        REG_NUM_SOURCES: num_sources <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_idx     = s_tdata[IDX_W-1:0];
  assign in_off     = s_tdata[IDX_W+OFF_W-1:IDX_W];
  assign in_data    = s_tdata[IDX_W+OFF_W+BYTE_W-1:IDX_W+OFF_W];
  assign in_off_ext = EXT_W'(in_off);
  assign in_addr    = in_off_ext[AW-1:0];
  assign in_keep    = (in_idx < num_sources) && (in_off_ext < EXT_W'(PACKET_BYTES));

  assign s1_fire  = s1_valid && (!s1_emit || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_fire && in_keep;
      byp_hit  <= s_fire && in_keep && s1_fire && (s1_addr == in_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1_addr <= in_addr;
      s1_off  <= in_off;
      s1_data <= in_data;
      s1_top  <= (in_idx == (num_sources - 8'd1));
      s1_emit <= (in_idx == '0);
      byp_val <= acc;
    end
  end

  gppe_col_ram #(
    .DEPTH (PACKET_BYTES),
    .AW    (AW)
  ) u_col_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_addr),
    .wdata (acc),
    .re    (s_tready),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  assign acc_old = byp_hit ? byp_val : rd_data;
  assign acc     = s1_top ? s1_data : (gf_mul(acc_old, eval_point) ^ s1_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      m_tdata <= OUT_TDATA_W'({acc, s1_off});
    end
  end

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && s1_emit && m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  a_bypass_live: assert property (@(posedge clk) disable iff (rst)
    byp_hit |-> s1_valid)
    else $error("bypass flagged with no item in flight");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_emit) |=> m_tvalid)
    else $error("finished column did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(s1_fire && s1_emit))
    else $error("pending result overwritten");
`endif

endmodule
